// ===== rtl/core/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg: shared types for the generational handle allocator
// Request kinds, sequencer states and the slot update unit's opcodes and status.
// ----------------------------------------------------------------------------
package gha_pkg;

    // Width of the generation field on the ports
    localparam int HGEN_W = 32;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_SLOT,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        ALU_TAKE,
        ALU_RELEASE,
        ALU_PROBE,
        ALU_RETIRE
    } alu_op_t;

    typedef struct packed {
        logic hit;
        logic next_alive;
    } alu_status_t;

endpackage

// ===== rtl/core/gha_slot_alu.sv =====
// ----------------------------------------------------------------------------
// gha_slot_alu: slot entry compare and update unit
// Matches a handle against a slot entry and forms the entry's new value.
// ----------------------------------------------------------------------------
module gha_slot_alu
    import gha_pkg::*;
#(
    parameter int GEN_BITS = 32
)
(
    input  alu_op_t             op,
    input  logic                slot_alive,
    input  logic [GEN_BITS-1:0] slot_gen,
    input  logic [HGEN_W-1:0]   handle_gen,
    output alu_status_t         status,
    output logic [GEN_BITS-1:0] next_gen
);

    logic                match;
    logic [GEN_BITS-1:0] bumped;

    // Bits of the handle above GEN_BITS must be zero to match
    assign match  = (HGEN_W'(slot_gen) == handle_gen);
    assign bumped = slot_gen + GEN_BITS'(1);

    always_comb
    begin
        status.hit        = slot_alive & match;
        status.next_alive = slot_alive;
        next_gen          = slot_gen;
        case (op)
            ALU_TAKE:
            begin
                status.hit        = 1'b1;
                status.next_alive = 1'b1;
            end
            ALU_RELEASE:
            begin
                status.next_alive = 1'b0;
                next_gen          = bumped;
            end
            ALU_PROBE:
            begin
                status.next_alive = slot_alive;
            end
            ALU_RETIRE:
            begin
                status.hit        = slot_alive;
                status.next_alive = 1'b0;
                next_gen          = slot_alive ? bumped : slot_gen;
            end
            default:
            begin
                status.next_alive = slot_alive;
            end
        endcase
    end

endmodule

// ===== rtl/core/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot map with generation counters
// Allocates, frees and checks handles made of a slot index and a generation.
// ----------------------------------------------------------------------------
// One request is worked on at a time; in_ready is high only while the
// sequencer is idle. A finished result moves into a single output register,
// so the next request can be taken while that result waits for out_ready; the
// sequencer holds a second finished result until the output register frees.
// From accept to out_valid: an allocate of a never-used slot or a refused
// allocate goes straight to hand-off; an allocate from the free stack passes
// stack read, slot read and write back, hand-off; free and check pass slot
// read, compare and write back, hand-off, or go straight to hand-off when the
// index lies beyond the high-water mark. Clear walks every slot below the
// high-water mark with a read state and a write state per slot. in_ready
// returns in the cycle that out_valid rises. Slots at or above the high-water
// mark are never read, so the slot memory needs no clearing pass after reset.
module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int GEN_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [$clog2(CAPACITY)-1:0] handle_index,
    input  logic [HGEN_W-1:0]           handle_generation,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [$clog2(CAPACITY)-1:0] out_index,
    output logic [HGEN_W-1:0]           out_generation,
    output logic [$clog2(CAPACITY+1)-1:0] live_count
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = GEN_BITS + 1;

    // Slot memory entry: {alive, generation}
    logic [SLOT_W-1:0] slot_mem [CAPACITY];
    logic [IDX_W-1:0]  stack_mem [CAPACITY];

    state_t state_reg, state_next;

    // Bookkeeping counters
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] hw_reg, hw_next;
    logic [CNT_W-1:0] live_reg, live_next;

    // Latched request and walk position
    kind_t             kind_reg, kind_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [HGEN_W-1:0] gen_reg, gen_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;

    // Result registers
    logic              ok_reg, ok_next;
    logic [IDX_W-1:0]  oidx_reg, oidx_next;
    logic [HGEN_W-1:0] ogen_reg, ogen_next;

    // Output register: the result offered to the consumer
    logic              out_valid_reg, out_valid_next;
    logic              rsp_ok_reg;
    logic [IDX_W-1:0]  rsp_index_reg;
    logic [HGEN_W-1:0] rsp_gen_reg;
    logic [CNT_W-1:0]  rsp_live_reg;
    logic              load_out;

    // Memory ports
    logic              slot_re, slot_we;
    logic [IDX_W-1:0]  slot_raddr, slot_waddr;
    logic [SLOT_W-1:0] slot_wdata, slot_rdata_reg;
    logic              stack_re, stack_we;
    logic [IDX_W-1:0]  stack_raddr, stack_waddr, stack_wdata, stack_rdata_reg;

    // Shared update unit
    alu_op_t             alu_op;
    alu_status_t         alu_status;
    logic [GEN_BITS-1:0] alu_next_gen;

    logic [CNT_W-1:0] depth_dec;
    logic             in_range;
    logic             scan_last;

    assign depth_dec = depth_reg - CNT_W'(1);
    assign in_range  = (CNT_W'(index_reg) < hw_reg);
    assign scan_last = (CNT_W'(scan_reg) == (hw_reg - CNT_W'(1)));

    gha_slot_alu #(
        .GEN_BITS (GEN_BITS)
    ) u_alu (
        .op         (alu_op),
        .slot_alive (slot_rdata_reg[SLOT_W-1]),
        .slot_gen   (slot_rdata_reg[GEN_BITS-1:0]),
        .handle_gen (gen_reg),
        .status     (alu_status),
        .next_gen   (alu_next_gen)
    );

    // Hand the finished result over once the output register is free or draining
    assign load_out       = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);
    assign out_valid_next = load_out | (out_valid_reg & ~out_ready);

    // Handshake and result ports
    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign ok             = rsp_ok_reg;
    assign out_index      = rsp_index_reg;
    assign out_generation = rsp_gen_reg;
    assign live_count     = rsp_live_reg;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (kind_reg)
                    KIND_ALLOC:
                        state_next = (depth_reg != '0) ? ST_POP : ST_RESP;
                    KIND_FREE, KIND_CHECK:
                        state_next = in_range ? ST_SLOT : ST_RESP;
                    KIND_CLEAR:
                        state_next = (hw_reg == '0) ? ST_RESP : ST_CLR_RD;
                    default:
                        state_next = ST_RESP;
                endcase
            end
            ST_POP:    state_next = ST_SLOT;
            ST_SLOT:   state_next = ST_RESP;
            ST_CLR_RD: state_next = ST_CLR_WR;
            ST_CLR_WR: state_next = scan_last ? ST_RESP : ST_CLR_RD;
            ST_RESP:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register updates
    always_comb
    begin
        depth_next  = depth_reg;
        hw_next     = hw_reg;
        live_next   = live_reg;
        kind_next   = kind_reg;
        index_next  = index_reg;
        gen_next    = gen_reg;
        scan_next   = scan_reg;
        ok_next     = ok_reg;
        oidx_next   = oidx_reg;
        ogen_next   = ogen_reg;

        slot_re     = 1'b0;
        slot_raddr  = index_reg;
        slot_we     = 1'b0;
        slot_waddr  = index_reg;
        slot_wdata  = {alu_status.next_alive, alu_next_gen};
        stack_re    = 1'b0;
        stack_raddr = depth_dec[IDX_W-1:0];
        stack_we    = 1'b0;
        stack_waddr = depth_reg[IDX_W-1:0];
        stack_wdata = index_reg;
        alu_op      = ALU_PROBE;

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the request
                if (in_valid)
                begin
                    kind_next  = kind_t'(kind);
                    index_next = handle_index;
                    gen_next   = handle_generation;
                end
            end
            ST_EXEC:
            begin
                ok_next   = 1'b0;
                oidx_next = '0;
                ogen_next = '0;
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if (depth_reg != '0)
                        begin
                            // Pop the most recently freed index
                            stack_re   = 1'b1;
                            depth_next = depth_dec;
                        end
                        else if (hw_reg < CNT_W'(CAPACITY))
                        begin
                            // Take a never-used slot; its generation is zero
                            slot_we    = 1'b1;
                            slot_waddr = hw_reg[IDX_W-1:0];
                            slot_wdata = {1'b1, {GEN_BITS{1'b0}}};
                            ok_next    = 1'b1;
                            oidx_next  = hw_reg[IDX_W-1:0];
                            hw_next    = hw_reg + CNT_W'(1);
                            live_next  = live_reg + CNT_W'(1);
                        end
                    end
                    KIND_FREE, KIND_CHECK:
                    begin
                        slot_re = in_range;
                    end
                    KIND_CLEAR:
                    begin
                        scan_next = '0;
                        if (hw_reg == '0)
                        begin
                            depth_next = '0;
                            live_next  = '0;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_POP:
            begin
                // Fetch the slot named by the popped index
                index_next = stack_rdata_reg;
                slot_re    = 1'b1;
                slot_raddr = stack_rdata_reg;
            end
            ST_SLOT:
            begin
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        alu_op    = ALU_TAKE;
                        slot_we   = 1'b1;
                        ok_next   = 1'b1;
                        oidx_next = index_reg;
                        ogen_next = HGEN_W'(slot_rdata_reg[GEN_BITS-1:0]);
                        live_next = live_reg + CNT_W'(1);
                    end
                    KIND_FREE:
                    begin
                        alu_op = ALU_RELEASE;
                        if (alu_status.hit)
                        begin
                            // Kill the slot, bump its generation, push the index
                            slot_we    = 1'b1;
                            stack_we   = 1'b1;
                            depth_next = depth_reg + CNT_W'(1);
                            live_next  = live_reg - CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        alu_op  = ALU_PROBE;
                        ok_next = alu_status.hit;
                    end
                endcase
            end
            ST_CLR_RD:
            begin
                slot_re    = 1'b1;
                slot_raddr = scan_reg;
            end
            ST_CLR_WR:
            begin
                // Retire a live slot and refill the stack in ascending order
                alu_op      = ALU_RETIRE;
                slot_we     = alu_status.hit;
                slot_waddr  = scan_reg;
                stack_we    = 1'b1;
                stack_waddr = scan_reg;
                stack_wdata = scan_reg;
                scan_next   = scan_reg + IDX_W'(1);
                if (scan_last)
                begin
                    depth_next = hw_reg;
                    live_next  = '0;
                end
            end
            default:
            begin
                alu_op = ALU_PROBE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            hw_reg        <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            hw_reg        <= hw_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        gen_reg   <= gen_next;
        scan_reg  <= scan_next;
        ok_reg    <= ok_next;
        oidx_reg  <= oidx_next;
        ogen_reg  <= ogen_next;
        if (load_out)
        begin
            rsp_ok_reg    <= ok_reg;
            rsp_index_reg <= oidx_reg;
            rsp_gen_reg   <= ogen_reg;
            rsp_live_reg  <= live_reg;
        end
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_rdata_reg <= slot_mem[slot_raddr];
    end

    // Free stack memory
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        if (stack_re)
            stack_rdata_reg <= stack_mem[stack_raddr];
    end

endmodule

// ===== sim/gha_result_checker.sv =====
// ----------------------------------------------------------------------------
// gha_result_checker: scoreboard for the generational handle allocator
// Mirrors the slot map on every accepted request and compares each result
// with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module gha_result_checker
    import gha_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [$clog2(CAPACITY)-1:0]   handle_index,
    input  logic [HGEN_W-1:0]             handle_generation,

    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          ok,
    input  logic [$clog2(CAPACITY)-1:0]   out_index,
    input  logic [HGEN_W-1:0]             out_generation,
    input  logic [$clog2(CAPACITY+1)-1:0] live_count,

    output int                            fail_count,
    output int                            pending
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  index;
        logic [HGEN_W-1:0] generation;
        logic [CNT_W-1:0]  live;
    } alloc_result_t;

    // Mirror of the slot map
    logic [HGEN_W-1:0] slot_gen [CAPACITY];
    bit                slot_live [CAPACITY];
    logic [IDX_W-1:0]  recycled [CAPACITY];
    int                recycled_depth;
    int                high_mark;
    int                live_total;

    alloc_result_t     awaited_results [$];

    task automatic report_mismatch(input string what, input logic [HGEN_W-1:0] got,
                                   input logic [HGEN_W-1:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic bit handle_is_live(input logic [IDX_W-1:0] idx,
                                          input logic [HGEN_W-1:0] gen);
        if (int'(idx) >= high_mark)
            return 1'b0;
        return slot_live[idx] && (slot_gen[idx] == gen);
    endfunction

    // Update the mirror for one request and return the result it must produce
    function automatic alloc_result_t apply_request(input kind_t k,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [HGEN_W-1:0] gen);
        alloc_result_t r;
        logic [IDX_W-1:0] slot;
        bit granted;
        r = '0;
        slot = '0;
        granted = 1'b0;
        case (k)
            KIND_ALLOC:
            begin
                // LIFO reuse first, then a never-used slot
                if (recycled_depth > 0)
                begin
                    recycled_depth--;
                    slot = recycled[recycled_depth];
                    granted = 1'b1;
                end
                else if (high_mark < CAPACITY)
                begin
                    slot = IDX_W'(high_mark);
                    high_mark++;
                    granted = 1'b1;
                end
                if (granted)
                begin
                    slot_live[slot] = 1'b1;
                    live_total++;
                    r.ok = 1'b1;
                    r.index = slot;
                    r.generation = slot_gen[slot];
                end
            end
            KIND_FREE:
            begin
                if (handle_is_live(idx, gen))
                begin
                    slot_live[idx] = 1'b0;
                    slot_gen[idx] = slot_gen[idx] + 1'b1;
                    if (recycled_depth < CAPACITY)
                    begin
                        recycled[recycled_depth] = idx;
                        recycled_depth++;
                    end
                    if (live_total > 0)
                        live_total--;
                    r.ok = 1'b1;
                end
            end
            KIND_CHECK:
            begin
                r.ok = handle_is_live(idx, gen);
            end
            default:
            begin
                // Kill every live slot, then restack 0 .. high_mark-1 ascending
                for (int i = 0; i < high_mark; i++)
                begin
                    if (slot_live[i])
                    begin
                        slot_live[i] = 1'b0;
                        slot_gen[i] = slot_gen[i] + 1'b1;
                    end
                    recycled[i] = IDX_W'(i);
                end
                recycled_depth = high_mark;
                live_total = 0;
            end
        endcase
        r.live = CNT_W'(live_total);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_gen[i] = '0;
                slot_live[i] = 1'b0;
            end
            recycled_depth = 0;
            high_mark = 0;
            live_total = 0;
            awaited_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // Take the request first: a result accepted on the same edge is older
            if (in_valid && in_ready)
                awaited_results.insert(awaited_results.size(),
                                       apply_request(kind_t'(kind), handle_index,
                                                     handle_generation));
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no request outstanding", '0, '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (ok !== want.ok)
                        report_mismatch("ok", HGEN_W'(ok), HGEN_W'(want.ok));
                    if (out_index !== want.index)
                        report_mismatch("out_index", HGEN_W'(out_index), HGEN_W'(want.index));
                    if (out_generation !== want.generation)
                        report_mismatch("out_generation", out_generation, want.generation);
                    if (live_count !== want.live)
                        report_mismatch("live_count", HGEN_W'(live_count), HGEN_W'(want.live));
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the generational handle allocator
// Drives directed and random allocate, free, check and clear requests with
// random idling on both channels; the scoreboard beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_top
    import gha_pkg::*;
();

    localparam int CAPACITY = 1024;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Slowest legal run: every request a clear over a full table plus the
    // longest gap and stall on each side, about 1500 requests, then several
    // times that. Time is 2 units a cycle.
    localparam longint RUN_LIMIT = 64'd20_000_000;

    // Long hold-off on the result side, so the block fills and backs up
    localparam int PARK_AT     = 500;
    localparam int PARK_CYCLES = 400;

    // Allocations in the fill phase: every slot plus a few refused ones
    localparam int FILL_ALLOCS = CAPACITY + 6;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [HGEN_W-1:0] gen;
    } handle_t;

    logic                clk;
    logic                rst_n;

    logic                in_valid;
    logic                in_ready;
    logic [1:0]          kind;
    logic [IDX_W-1:0]    handle_index;
    logic [HGEN_W-1:0]   handle_generation;

    logic                out_valid;
    logic                out_ready;
    logic                ok;
    logic [IDX_W-1:0]    out_index;
    logic [HGEN_W-1:0]   out_generation;
    logic [CNT_W-1:0]    live_count;

    int                  fail_count;
    int                  pending;

    // Handles the stimulus believes are live, and ones known to be stale.
    // The live list can lag the block by a request; the scoreboard does not care.
    handle_t             live_handles [$];
    handle_t             dead_handles [$];
    // Kinds of accepted requests, so the result side knows which were allocations
    kind_t               kinds_in_flight [$];

    int                  sender_calm;
    int                  receiver_calm;
    int                  results_taken;

    generational_handle_allocator #(
        .CAPACITY (CAPACITY),
        .GEN_BITS (HGEN_W)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ok                (ok),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .live_count        (live_count)
    );

    gha_result_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ok                (ok),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .live_count        (live_count),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle cycles before the next request or result. Now and then start a calm
    // stretch with no idling at all, so back-to-back traffic is covered too.
    function automatic int draw_wait(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        return IDX_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    // Mix small generations (likely hits), all-ones and fully random ones
    function automatic logic [HGEN_W-1:0] rand_generation();
        case ($urandom_range(0, 3))
            0:       return HGEN_W'($urandom_range(0, 3));
            1:       return '1;
            default: return HGEN_W'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until the block takes it. Keep valid high
    // across back-to-back requests instead of dropping and raising it.
    task automatic send_req(input kind_t k, input logic [IDX_W-1:0] idx,
                            input logic [HGEN_W-1:0] gen);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        kind              <= k;
        handle_index      <= idx;
        handle_generation <= gen;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        kinds_in_flight.insert(kinds_in_flight.size(), k);
    endtask

    // A clear kills every handle: move them all to the stale list
    task automatic retire_live_handles();
        foreach (live_handles[i])
            dead_handles.insert(dead_handles.size(), live_handles[i]);
        live_handles.delete();
    endtask

    task automatic send_clear();
        retire_live_handles();
        send_req(KIND_CLEAR, rand_index(), rand_generation());
    endtask

    // One random request: mostly well-formed use of held handles,
    // the rest stale handles and random noise
    task automatic issue_mixed(input int alloc_pct, input int clear_pct);
        int roll;
        int pick;
        handle_t h;
        roll = $urandom_range(0, 99);
        if (roll < clear_pct)
            send_clear();
        else if (roll < clear_pct + alloc_pct)
            send_req(KIND_ALLOC, rand_index(), rand_generation());
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 3 && live_handles.size() > 0)
            begin
                // Free a held handle; from now on it is stale
                pick = $urandom_range(0, live_handles.size() - 1);
                h = live_handles[pick];
                live_handles.delete(pick);
                dead_handles.insert(dead_handles.size(), h);
                send_req(KIND_FREE, h.idx, h.gen);
            end
            else if (pick <= 6 && live_handles.size() > 0)
            begin
                h = live_handles[$urandom_range(0, live_handles.size() - 1)];
                send_req(KIND_CHECK, h.idx, h.gen);
            end
            else if (pick == 7 && dead_handles.size() > 0)
            begin
                h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
                send_req($urandom_range(0, 1) ? KIND_FREE : KIND_CHECK, h.idx, h.gen);
            end
            else
                send_req(pick[0] ? KIND_FREE : KIND_CHECK, rand_index(), rand_generation());
        end
    endtask

    // Result side: stall at random, hold off once for a long stretch,
    // and harvest allocated handles for later frees and checks
    initial
    begin : result_sink
        int stall;
        kind_t k;
        handle_t got;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(receiver_calm);
            if (results_taken == PARK_AT)
                stall = PARK_CYCLES;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (kinds_in_flight.size() > 0)
            begin
                k = kinds_in_flight.pop_front();
                if (k == KIND_ALLOC && ok)
                begin
                    got.idx = out_index;
                    got.gen = out_generation;
                    live_handles.insert(live_handles.size(), got);
                end
            end
            results_taken++;
        end
    end

    // Stimulus and verdict
    initial
    begin : request_source
        int allocs;
        handle_t h;

        rst_n             = 1'b0;
        in_valid          = 1'b0;
        kind              = KIND_ALLOC;
        handle_index      = '0;
        handle_generation = '0;
        sender_calm       = 0;
        receiver_calm     = 0;
        results_taken     = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, out-of-range and stale handles, LIFO reuse,
        // clear with live slots and clear of an already dead table
        send_req(KIND_CHECK, '0, '0);
        send_req(KIND_FREE,  '0, '0);
        send_req(KIND_ALLOC, rand_index(), rand_generation());
        send_req(KIND_ALLOC, rand_index(), rand_generation());
        send_req(KIND_ALLOC, rand_index(), rand_generation());
        send_req(KIND_CHECK, 10'd0, 32'd0);
        send_req(KIND_CHECK, 10'd1, 32'hFFFF_FFFF);
        send_req(KIND_CHECK, 10'd1023, 32'd0);
        send_req(KIND_FREE,  10'd1, 32'd0);
        send_req(KIND_FREE,  10'd1, 32'd0);
        send_req(KIND_CHECK, 10'd1, 32'd1);
        send_req(KIND_ALLOC, rand_index(), rand_generation());
        send_req(KIND_CHECK, 10'd1, 32'd1);
        send_req(KIND_FREE,  10'd2, 32'd1);
        send_req(KIND_FREE,  10'd0, 32'd0);
        send_req(KIND_FREE,  10'd2, 32'd0);
        send_req(KIND_ALLOC, rand_index(), rand_generation());
        send_clear();
        send_req(KIND_CHECK, 10'd2, 32'd1);
        repeat (4) send_req(KIND_ALLOC, rand_index(), rand_generation());
        send_clear();
        send_clear();
        send_req(KIND_FREE,  10'd1023, 32'hFFFF_FFFF);
        send_req(KIND_CHECK, 10'd682, 32'hAAAA_5555);

        // Random mix while the table is still partly unused
        repeat (150) issue_mixed(40, 3);

        // Fill: clear, then allocate every slot and run into the full table,
        // with checks of held handles sprinkled in
        send_clear();
        allocs = 0;
        while (allocs < FILL_ALLOCS)
        begin
            if ($urandom_range(0, 19) == 0 && live_handles.size() > 0)
            begin
                h = live_handles[$urandom_range(0, live_handles.size() - 1)];
                send_req(KIND_CHECK, h.idx, h.gen);
            end
            else
            begin
                send_req(KIND_ALLOC, rand_index(), rand_generation());
                allocs++;
            end
        end

        // Full high-water mark: free and reuse, then clear the whole table
        repeat (100) issue_mixed(25, 0);
        send_clear();
        repeat (20) issue_mixed(50, 0);
        in_valid <= 1'b0;

        // Drain outstanding results, then give a stray result time to show up
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("generational_handle_allocator regression: pass");
        else
            $display("generational_handle_allocator regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("generational_handle_allocator regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gha_pkg.sv
rtl/core/gha_slot_alu.sv
rtl/core/generational_handle_allocator.sv
sim/gha_result_checker.sv
sim/tb_top.sv
